[rtl/core/macd_pkg.sv]
// Shared types and constants of the moving average crossover detector.
package macd_pkg;

  // Field widths fixed by the register map and the result item
  localparam int PERIOD_W  = 7;
  localparam int QTY_W     = 16;
  localparam int SIG_W     = 2;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PERIOD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_SIZE   = 2'd2;

  // Register reset values
  localparam logic [PERIOD_W-1:0] SHORT_PERIOD_RST = 7'd20;
  localparam logic [PERIOD_W-1:0] LONG_PERIOD_RST  = 7'd50;
  localparam logic [QTY_W-1:0]    ORDER_SIZE_RST   = 16'd1000;

  // Width of the low slice of a sum fed to one multiplier
  localparam int MUL_SPLIT = 32;

  // Result queue geometry
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

  // Relation of the short average to the long average
  typedef enum logic [1:0] {
    REL_BELOW = 2'd0,
    REL_EQUAL = 2'd1,
    REL_ABOVE = 2'd2
  } rel_t;

  // Signal codes of a result item
  typedef enum logic [SIG_W-1:0] {
    SIG_NONE = 2'd0,
    SIG_BUY  = 2'd1,
    SIG_SELL = 2'd2
  } sig_t;

  // Handoff from the history stage to the compare pipeline
  typedef struct packed {
    logic valid;
    logic gate;
  } hist_ctl_t;

  // One result item as held in the queue
  typedef struct packed {
    sig_t             sig;
    logic [QTY_W-1:0] qty;
  } out_item_t;

endpackage

[rtl/core/macd_if.sv]
// Valid/ready channel interfaces for price items and signal items.
interface macd_price_if #(
  parameter int W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] price;

  modport source (output valid, output price, input ready);
  modport sink   (input valid, input price, output ready);
endinterface

interface macd_signal_if;
  logic                          valid;
  logic                          ready;
  logic [macd_pkg::SIG_W-1:0]    signal;
  logic [macd_pkg::QTY_W-1:0]    order_quantity;

  modport source (output valid, output signal, output order_quantity, input ready);
  modport sink   (input valid, input signal, input order_quantity, output ready);
endinterface

[rtl/core/macd_history.sv]
// Price history memory, window tail reads and running window sums.
module macd_history #(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          clear,
  input  logic                                          accept,
  input  logic [PRICE_BITS-1:0]                         price,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]               sp,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]               lp,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]               maxp,
  input  logic                                          room,
  output logic                                          ready,
  output logic [PRICE_BITS+$clog2(MAX_WINDOW)-1:0]      short_sum,
  output logic [PRICE_BITS+$clog2(MAX_WINDOW)-1:0]      long_sum,
  output macd_pkg::hist_ctl_t                           ctl
);

  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int EXT_W = CNT_W + 1;
  localparam int SUM_W = PRICE_BITS + IDX_W;

  typedef enum logic [1:0] {
    ST_READY = 2'b01,
    ST_LONG  = 2'b10
  } st_t;

  st_t                   st;
  logic [PRICE_BITS-1:0] mem [MAX_WINDOW];
  logic [IDX_W-1:0]      wp;
  logic [IDX_W-1:0]      wp_next;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [IDX_W-1:0]      rd_addr;
  logic [PRICE_BITS-1:0] rd_q;
  logic                  rd_ok;
  logic [PRICE_BITS-1:0] price_q;
  logic [PRICE_BITS-1:0] short_tail_q;
  logic [PRICE_BITS-1:0] long_tail;
  logic                  gate_q;
  logic                  upd;

  // Slot that leaves a window of the given length when the next sample lands
  function automatic logic [IDX_W-1:0] tail_of(input logic [IDX_W-1:0] ptr,
                                               input logic [CNT_W-1:0] per);
    logic [EXT_W-1:0] t;
    t = EXT_W'(ptr) + EXT_W'(MAX_WINDOW) - EXT_W'(per);
    if (t >= EXT_W'(MAX_WINDOW)) t = t - EXT_W'(MAX_WINDOW);
    return t[IDX_W-1:0];
  endfunction

  // Short tail on the accept cycle, long tail on the following one
  assign rd_addr    = (st == ST_LONG) ? tail_of(wp, lp) : tail_of(wp, sp);
  assign wp_next    = (wp == IDX_W'(MAX_WINDOW - 1)) ? '0 : wp + 1'b1;
  assign count_next = (count == CNT_W'(MAX_WINDOW)) ? count : count + 1'b1;
  assign long_tail  = rd_ok ? rd_q : '0;
  assign ready      = (st == ST_READY) && room;

  // History memory: read every cycle, write the new sample after both tails
  always_ff @(posedge clk) begin
    if (st == ST_LONG) mem[wp] <= price_q;
    rd_q  <= mem[rd_addr];
    // Slots at or above the fill count were never written since the last clear
    rd_ok <= (CNT_W'(rd_addr) < count);
  end

  // Hold the sample and the short tail until the sums update
  always_ff @(posedge clk) begin
    if (accept) price_q <= price;
    if (st == ST_LONG) begin
      short_tail_q <= rd_ok ? rd_q : '0;
      gate_q       <= (count_next >= maxp);
    end
  end

  // Sequencer, pointer, fill count and running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_READY;
      wp        <= '0;
      count     <= '0;
      upd       <= 1'b0;
      ctl       <= '0;
      short_sum <= '0;
      long_sum  <= '0;
    end else begin
      upd       <= (st == ST_LONG);
      ctl.valid <= upd;
      ctl.gate  <= gate_q;
      unique case (st)
        ST_READY: if (accept) st <= ST_LONG;
        ST_LONG:  st <= ST_READY;
        default:  st <= ST_READY;
      endcase
      if (clear) begin
        wp        <= '0;
        count     <= '0;
        short_sum <= '0;
        long_sum  <= '0;
      end else begin
        if (st == ST_LONG) begin
          wp    <= wp_next;
          count <= count_next;
        end
        if (upd) begin
          short_sum <= short_sum - SUM_W'(short_tail_q) + SUM_W'(price_q);
          long_sum  <= long_sum - SUM_W'(long_tail) + SUM_W'(price_q);
        end
      end
    end
  end

`ifndef SYNTHESIS
  // Sums reach the compare pipeline after the long tail read, by way of upd and ctl
  a_ctl_after_long: assert property (@(posedge clk) disable iff (rst)
    ctl.valid |-> $past(st == ST_LONG, 2))
    else $error("window sums handed on without a preceding tail read");
`endif

endmodule

[rtl/core/macd_compare.sv]
// Cross-multiplied average compare, crossover detection and result build.
module macd_compare #(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     clear,
  input  macd_pkg::hist_ctl_t                      ctl,
  input  logic [PRICE_BITS+$clog2(MAX_WINDOW)-1:0] short_sum,
  input  logic [PRICE_BITS+$clog2(MAX_WINDOW)-1:0] long_sum,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]          sp,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]          lp,
  input  logic [macd_pkg::QTY_W-1:0]               order_size,
  output logic                                     push,
  output macd_pkg::out_item_t                      item
);

  localparam int PER_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = PRICE_BITS + $clog2(MAX_WINDOW);
  localparam int SPLIT  = macd_pkg::MUL_SPLIT;
  localparam int HI_W   = (SUM_W > SPLIT) ? SUM_W - SPLIT : 1;
  localparam int PAD_W  = SPLIT + HI_W;
  localparam int LO_PW  = SPLIT + PER_W;
  localparam int HI_PW  = HI_W + PER_W;
  localparam int PROD_W = PAD_W + PER_W;

  logic [PAD_W-1:0]    s_pad;
  logic [PAD_W-1:0]    l_pad;
  logic [LO_PW-1:0]    s_lo_p;
  logic [HI_PW-1:0]    s_hi_p;
  logic [LO_PW-1:0]    l_lo_p;
  logic [HI_PW-1:0]    l_hi_p;
  logic                v1;
  logic                g1;
  logic [PROD_W-1:0]   s_full;
  logic [PROD_W-1:0]   l_full;
  logic                v2;
  logic                g2;
  macd_pkg::rel_t      rel;
  macd_pkg::rel_t      prev_rel;
  macd_pkg::sig_t      sig;

  assign s_pad = PAD_W'(short_sum);
  assign l_pad = PAD_W'(long_sum);

  // Stage 1: partial products, short sum times long period and vice versa
  always_ff @(posedge clk) begin
    s_lo_p <= LO_PW'(s_pad[SPLIT-1:0]) * LO_PW'(lp);
    s_hi_p <= HI_PW'(s_pad[PAD_W-1:SPLIT]) * HI_PW'(lp);
    l_lo_p <= LO_PW'(l_pad[SPLIT-1:0]) * LO_PW'(sp);
    l_hi_p <= HI_PW'(l_pad[PAD_W-1:SPLIT]) * HI_PW'(sp);
    g1     <= ctl.gate;
  end

  // Stage 2: assemble the full products
  always_ff @(posedge clk) begin
    s_full <= (PROD_W'(s_hi_p) << SPLIT) + PROD_W'(s_lo_p);
    l_full <= (PROD_W'(l_hi_p) << SPLIT) + PROD_W'(l_lo_p);
    g2     <= g1;
  end

  // Stage 3: relation and crossover against the previous relation
  always_comb begin
    priority if (s_full > l_full) rel = macd_pkg::REL_ABOVE;
    else if (s_full == l_full)    rel = macd_pkg::REL_EQUAL;
    else                          rel = macd_pkg::REL_BELOW;
  end

  always_comb begin
    priority if (g2 && rel == macd_pkg::REL_ABOVE && prev_rel != macd_pkg::REL_ABOVE)
      sig = macd_pkg::SIG_BUY;
    else if (g2 && rel == macd_pkg::REL_BELOW && prev_rel != macd_pkg::REL_BELOW)
      sig = macd_pkg::SIG_SELL;
    else
      sig = macd_pkg::SIG_NONE;
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (v2) begin
      item.sig <= sig;
      item.qty <= (sig != macd_pkg::SIG_NONE) ? order_size : '0;
    end
  end

  // Valid chain and stored relation
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      push     <= 1'b0;
      prev_rel <= macd_pkg::REL_EQUAL;
    end else begin
      v1   <= ctl.valid;
      v2   <= v1;
      push <= v2;
      if (clear)   prev_rel <= macd_pkg::REL_EQUAL;
      else if (v2) prev_rel <= rel;
    end
  end

endmodule

[rtl/core/macd_outq.sv]
// Result queue that decouples the compare pipeline from the output channel.
module macd_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  macd_pkg::out_item_t item,
  macd_signal_if.source       out_ch
);

  macd_pkg::out_item_t                 q [macd_pkg::OUTQ_DEPTH];
  logic [macd_pkg::OUTQ_PTR_W-1:0]     wr_ptr;
  logic [macd_pkg::OUTQ_PTR_W-1:0]     rd_ptr;
  logic [macd_pkg::OUTQ_CNT_W-1:0]     count;
  logic                                pop;

  assign pop                   = out_ch.valid && out_ch.ready;
  assign out_ch.valid          = (count != '0);
  assign out_ch.signal         = q[rd_ptr].sig;
  assign out_ch.order_quantity = q[rd_ptr].qty;

  // Store entries
  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= item;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The in-flight limit upstream keeps the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < macd_pkg::OUTQ_CNT_W'(macd_pkg::OUTQ_DEPTH)))
    else $error("result queue written while full");
`endif

endmodule

[rtl/core/moving_average_crossover_detector.sv]
// Top level of the moving average crossover detector.
//
// One price item in, one signal item out, in order. The block cannot take a new
// item while it still reads the tails for the last one: the history memory has
// a single read port and each sample needs two reads from it (the tails of the
// short and the long window), and the new sample is written on the second of those
// cycles. A result passes the window sums, the compare stages and the result queue;
// up to 4 items may be in flight, so input is held off once 4 items are accepted but not yet delivered.
// Writing short_period or long_period restarts the detector at once: the
// history is cleared by resetting its fill count, so there is no clearing
// pass after reset or after a period write. Periods of 0 act as 1 and periods
// above MAX_WINDOW act as MAX_WINDOW. Write registers only while idle.
module moving_average_crossover_detector #(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  macd_price_if.sink                        in_ch,
  macd_signal_if.source                     out_ch,
  input  logic                              cfg_we,
  input  logic [macd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [macd_pkg::CFG_W-1:0]        cfg_data
);

  localparam int PER_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = PRICE_BITS + $clog2(MAX_WINDOW);
  localparam int EXT_W = (PER_W > macd_pkg::PERIOD_W) ? PER_W : macd_pkg::PERIOD_W;

  logic [macd_pkg::PERIOD_W-1:0]   short_period;
  logic [macd_pkg::PERIOD_W-1:0]   long_period;
  logic [macd_pkg::QTY_W-1:0]      order_size;
  logic                            clear;
  logic [PER_W-1:0]                sp;
  logic [PER_W-1:0]                lp;
  logic [PER_W-1:0]                maxp;
  logic                            in_acc;
  logic                            out_acc;
  logic [macd_pkg::OUTQ_CNT_W-1:0] inflight;
  logic                            room;
  logic [SUM_W-1:0]                short_sum;
  logic [SUM_W-1:0]                long_sum;
  macd_pkg::hist_ctl_t             ctl;
  logic                            push;
  macd_pkg::out_item_t             item;

  // Clamp a period register into 1..MAX_WINDOW
  function automatic logic [PER_W-1:0] eff_period(input logic [macd_pkg::PERIOD_W-1:0] p);
    logic [EXT_W-1:0] e;
    e = EXT_W'(p);
    if (e == '0) e = EXT_W'(1);
    else if (e > EXT_W'(MAX_WINDOW)) e = EXT_W'(MAX_WINDOW);
    return e[PER_W-1:0];
  endfunction

  assign sp      = eff_period(short_period);
  assign lp      = eff_period(long_period);
  assign maxp    = (sp > lp) ? sp : lp;
  assign clear   = cfg_we && (cfg_index == macd_pkg::REG_SHORT_PERIOD ||
                              cfg_index == macd_pkg::REG_LONG_PERIOD);
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign room    = (inflight < macd_pkg::OUTQ_CNT_W'(macd_pkg::OUTQ_DEPTH));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      short_period <= macd_pkg::SHORT_PERIOD_RST;
      long_period  <= macd_pkg::LONG_PERIOD_RST;
      order_size   <= macd_pkg::ORDER_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        macd_pkg::REG_SHORT_PERIOD: short_period <= cfg_data[macd_pkg::PERIOD_W-1:0];
        macd_pkg::REG_LONG_PERIOD:  long_period  <= cfg_data[macd_pkg::PERIOD_W-1:0];
        macd_pkg::REG_ORDER_SIZE:   order_size   <= cfg_data[macd_pkg::QTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Count items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      unique case ({in_acc, out_acc})
        2'b10:   inflight <= inflight + 1'b1;
        2'b01:   inflight <= inflight - 1'b1;
        default: inflight <= inflight;
      endcase
    end
  end

  macd_history #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_history (
    .clk       (clk),
    .rst       (rst),
    .clear     (clear),
    .accept    (in_acc),
    .price     (in_ch.price),
    .sp        (sp),
    .lp        (lp),
    .maxp      (maxp),
    .room      (room),
    .ready     (in_ch.ready),
    .short_sum (short_sum),
    .long_sum  (long_sum),
    .ctl       (ctl)
  );

  macd_compare #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_compare (
    .clk        (clk),
    .rst        (rst),
    .clear      (clear),
    .ctl        (ctl),
    .short_sum  (short_sum),
    .long_sum   (long_sum),
    .sp         (sp),
    .lp         (lp),
    .order_size (order_size),
    .push       (push),
    .item       (item)
  );

  macd_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  // A result on the output always belongs to an accepted item
  a_out_has_item: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (inflight != '0))
    else $error("result offered with no item in flight");

  // Input is held off while the in-flight limit is reached
  a_limit_holds: assert property (@(posedge clk) disable iff (rst)
    !room |-> !in_ch.ready)
    else $error("item accepted beyond the in-flight limit");
`endif

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the moving average crossover detector.

// Tracks window sums and crossings for each price item and checks signal items in order
class crossover_scoreboard;
  localparam int WINDOW = 64;

  logic [31:0] ring [WINDOW];
  logic [5:0]  head;
  logic [63:0] short_total;
  logic [63:0] long_total;
  int          fill;
  macd_pkg::rel_t last_rel;

  logic [6:0]  short_len;
  logic [6:0]  long_len;
  logic [15:0] order_qty;

  macd_pkg::out_item_t expected_signals [$];
  int errors;

  function new();
    short_len = macd_pkg::SHORT_PERIOD_RST;
    long_len  = macd_pkg::LONG_PERIOD_RST;
    order_qty = macd_pkg::ORDER_SIZE_RST;
    errors    = 0;
    restart();
  endfunction

  // Clear history, sums, fill count and relation
  function void restart();
    foreach (ring[i]) ring[i] = '0;
    head        = '0;
    short_total = '0;
    long_total  = '0;
    fill        = 0;
    last_rel    = macd_pkg::REL_EQUAL;
  endfunction

  // Zero acts as one, anything above the ring depth acts as the depth
  function logic [6:0] clamp_period(logic [6:0] p);
    if (p == 7'd0) return 7'd1;
    if (p > 7'(WINDOW)) return 7'(WINDOW);
    return p;
  endfunction

  function void write_reg(logic [macd_pkg::CFG_IDX_W-1:0] idx,
                          logic [macd_pkg::CFG_W-1:0] data);
    case (idx)
      macd_pkg::REG_SHORT_PERIOD: begin
        short_len = data[6:0];
        restart();
      end
      macd_pkg::REG_LONG_PERIOD: begin
        long_len = data[6:0];
        restart();
      end
      macd_pkg::REG_ORDER_SIZE: begin
        order_qty = data[15:0];
      end
      default: begin
      end
    endcase
  endfunction

  // Advance the windows by one sample and queue the signal it should produce
  function void note_price(logic [31:0] price);
    logic [6:0]  sp;
    logic [6:0]  lp;
    logic [6:0]  widest;
    logic [5:0]  short_tail;
    logic [5:0]  long_tail;
    logic [63:0] short_cross;
    logic [63:0] long_cross;
    macd_pkg::rel_t rel;
    macd_pkg::out_item_t want;
    sp = clamp_period(short_len);
    lp = clamp_period(long_len);
    widest = (sp > lp) ? sp : lp;
    // read both tails before the new sample lands in its slot
    short_tail = head - sp[5:0];
    long_tail  = head - lp[5:0];
    short_total = short_total - 64'(ring[short_tail]) + 64'(price);
    long_total  = long_total - 64'(ring[long_tail]) + 64'(price);
    ring[head] = price;
    head = head + 6'd1;
    if (fill < WINDOW) fill++;

    // compare the averages by cross-multiplying with the other period
    short_cross = short_total * 64'(lp);
    long_cross  = long_total * 64'(sp);
    if (short_cross > long_cross) rel = macd_pkg::REL_ABOVE;
    else if (short_cross == long_cross) rel = macd_pkg::REL_EQUAL;
    else rel = macd_pkg::REL_BELOW;

    want.sig = macd_pkg::SIG_NONE;
    if (fill >= int'(widest)) begin
      if (rel == macd_pkg::REL_ABOVE && last_rel != macd_pkg::REL_ABOVE)
        want.sig = macd_pkg::SIG_BUY;
      else if (rel == macd_pkg::REL_BELOW && last_rel != macd_pkg::REL_BELOW)
        want.sig = macd_pkg::SIG_SELL;
    end
    last_rel = rel;
    want.qty = (want.sig != macd_pkg::SIG_NONE) ? order_qty : '0;
    expected_signals.insert(expected_signals.size(), want);
  endfunction

  function void check_signal(logic [1:0] sig, logic [15:0] qty);
    macd_pkg::out_item_t want;
    if (expected_signals.size() == 0) begin
      $error("signal item arrived with no price item outstanding");
      errors++;
      return;
    end
    want = expected_signals.pop_front();
    if (sig !== want.sig) begin
      $error("signal: expected %0d, actual %0d", want.sig, sig);
      errors++;
    end
    if (qty !== want.qty) begin
      $error("order_quantity: expected %0d, actual %0d", want.qty, qty);
      errors++;
    end
  endfunction

  function int pending();
    return expected_signals.size();
  endfunction
endclass

module tb_top;

  localparam logic [macd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam longint PRICE_TOP     = 64'hFFFF_FFFF;
  localparam int     RANDOM_ITEMS  = 1400;
  localparam int     HOLD_CYCLES   = 200;
  localparam int     SETTLE_CYCLES = 12;
  localparam int     LIMIT_TIME    = 3_000_000;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [macd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [macd_pkg::CFG_W-1:0]     cfg_data;

  macd_price_if #(.W(32)) price_ch();
  macd_signal_if          signal_ch();

  moving_average_crossover_detector DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (price_ch),
    .out_ch    (signal_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  crossover_scoreboard sb;
  bit hold_req;

  // Price walk state
  longint      walk_level;
  int          walk_dir;
  int unsigned walk_step;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample handshakes and register writes at the rising edge
  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (price_ch.valid && price_ch.ready) sb.note_price(price_ch.price);
      if (signal_ch.valid && signal_ch.ready)
        sb.check_signal(signal_ch.signal, signal_ch.order_quantity);
    end
  end

  // Trending walk with reversals so the averages cross, plus occasional noise
  function automatic logic [31:0] next_price();
    if ($urandom_range(0, 39) == 0) return $urandom();
    if ($urandom_range(0, 15) == 0) walk_dir = -walk_dir;
    walk_level += longint'(walk_dir) * longint'($urandom_range(0, walk_step));
    if (walk_level < 0) begin
      walk_level = 0;
      walk_dir = 1;
    end
    if (walk_level > PRICE_TOP) begin
      walk_level = PRICE_TOP;
      walk_dir = -1;
    end
    return walk_level[31:0];
  endfunction

  // Period value with random junk above the seven period bits
  function automatic logic [15:0] period_word(logic [6:0] p);
    logic [8:0] junk;
    junk = ($urandom_range(0, 1) == 1) ? 9'($urandom()) : 9'd0;
    return {junk, p};
  endfunction

  task automatic set_reg(input logic [macd_pkg::CFG_IDX_W-1:0] idx,
                         input logic [macd_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold one price item on the channel until it is taken
  task automatic offer(input logic [31:0] price);
    @(negedge clk);
    price_ch.valid <= 1'b1;
    price_ch.price <= price;
    do @(posedge clk); while (price_ch.ready !== 1'b1);
  endtask

  // Drop valid and wait for every outstanding signal item
  task automatic settle();
    @(negedge clk);
    price_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic feed(input logic [31:0] prices [$]);
    foreach (prices[i]) offer(prices[i]);
    settle();
  endtask

  // Send price items in bursts separated by random gaps
  task automatic stream(input int count);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) offer(next_price());
      left -= burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0 && left > 0) begin
        @(negedge clk);
        price_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Receiver: stretches of steady, random and sparse ready, plus one long hold-off
  initial begin
    int mode;
    int len;
    wait (rst === 1'b0);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(negedge clk);
        signal_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(8, 60);
        repeat (len) begin
          @(negedge clk);
          case (mode)
            0: signal_ch.ready <= 1'b1;
            1: signal_ch.ready <= 1'($urandom_range(0, 1));
            default: signal_ch.ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  // Main sequence
  initial begin
    int done;
    int phase;
    int count;
    logic [6:0] sp;
    logic [6:0] lp;

    sb = new();
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    price_ch.valid  = 1'b0;
    price_ch.price  = '0;
    signal_ch.ready = 1'b0;
    hold_req        = 1'b0;
    walk_level      = 0;
    walk_dir        = 1;
    walk_step       = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings with price extremes
    feed('{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0});

    // Short windows: upward then downward cross, junk above the period bits
    set_reg(macd_pkg::REG_SHORT_PERIOD, 16'hFF82);
    set_reg(macd_pkg::REG_LONG_PERIOD, 16'd3);
    feed('{32'd10, 32'd10, 32'd10, 32'd30, 32'd30, 32'd5, 32'd5, 32'd5});

    // Zero period acts as one: both windows equal, never a signal
    set_reg(macd_pkg::REG_SHORT_PERIOD, 16'd0);
    set_reg(macd_pkg::REG_LONG_PERIOD, 16'd1);
    feed('{32'd0, 32'hFFFF_FFFF, 32'd5});

    // Unknown index ignored, zero quantity on signals
    set_reg(REG_SPARE, 16'hFFFF);
    set_reg(macd_pkg::REG_ORDER_SIZE, 16'd0);
    set_reg(macd_pkg::REG_LONG_PERIOD, 16'd2);
    feed('{32'd100, 32'd200, 32'd50, 32'd300});

    // Short window longer than long window, full quantity
    set_reg(macd_pkg::REG_ORDER_SIZE, 16'hFFFF);
    set_reg(macd_pkg::REG_SHORT_PERIOD, 16'd3);
    set_reg(macd_pkg::REG_LONG_PERIOD, 16'd1);
    feed('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF});

    // Random phases, each with its own window settings
    done  = 0;
    phase = 0;
    while (done < RANDOM_ITEMS) begin
      case (phase)
        0: begin sp = 7'd20; lp = 7'd50; end
        1: begin sp = 7'd63; lp = 7'd64; end
        2: begin sp = 7'd1;  lp = 7'd64; end
        3: begin sp = 7'd64; lp = 7'd2;  end
        4: begin sp = 7'd0;  lp = 7'd127; end
        5: begin sp = 7'd127; lp = 7'd3; end
        default: begin
          sp = ($urandom_range(0, 1) == 1) ? 7'($urandom_range(1, 12))
                                           : 7'($urandom_range(1, 64));
          lp = ($urandom_range(0, 1) == 1) ? 7'($urandom_range(1, 24))
                                           : 7'($urandom_range(1, 64));
        end
      endcase
      set_reg(macd_pkg::REG_SHORT_PERIOD, period_word(sp));
      set_reg(macd_pkg::REG_LONG_PERIOD, period_word(lp));
      if (phase == 6) set_reg(macd_pkg::REG_ORDER_SIZE, 16'hFFFF);
      else if (phase == 7) set_reg(macd_pkg::REG_ORDER_SIZE, 16'd1);
      else if ($urandom_range(0, 1) == 1)
        set_reg(macd_pkg::REG_ORDER_SIZE, 16'($urandom_range(1, 65535)));

      walk_level = longint'($urandom());
      walk_dir   = ($urandom_range(0, 1) == 1) ? 1 : -1;
      case ($urandom_range(0, 2))
        0: walk_step = $urandom_range(1, 16);
        1: walk_step = $urandom_range(16, 4096);
        default: walk_step = $urandom_range(4096, 1 << 24);
      endcase

      if (phase == 2) hold_req = 1'b1;
      count = $urandom_range(90, 130);
      stream(count);
      settle();
      done += count;
      phase++;
    end

    if (sb.errors == 0) begin
      $display("moving_average_crossover_detector verification clean");
    end else begin
      $display("moving_average_crossover_detector verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #LIMIT_TIME;
    $display("moving_average_crossover_detector verification failed");
    $finish;
  end

endmodule
